// ===== hdl/cartridge_bank_controller_assert.svh =====
// assertion macros for the cartridge bank controller
`ifndef CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH

// condition that must hold at every edge out of reset
`define CBC_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("cartridge bank controller check failed");

// consequence that must hold in the cycle after the antecedent
`define CBC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cartridge bank controller check failed");

`endif

// ===== hdl/cbc_pkg.sv =====
// shared types and constants of the cartridge bank controller
package cbc_pkg;

   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 8;
   localparam int OFFSET_W   = 21;
   localparam int ROM_SIZE_W = 22;
   localparam int ROM_BANK_W = 7;
   localparam int EXT_BANK_W = 2;
   localparam int CLK_SEL_W  = 4;
   localparam int ROM_PAGE_W = 14;   // 16 KiB switchable ROM page
   localparam int RAM_PAGE_W = 13;   // 8 KiB extra RAM page
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = ROM_SIZE_W;

   typedef enum logic [2:0] {
      TGT_BOOT  = 3'd0,
      TGT_ROM   = 3'd1,
      TGT_XRAM  = 3'd2,
      TGT_OPEN  = 3'd3,
      TGT_FAULT = 3'd4,
      TGT_WDONE = 3'd5
   } target_type;

   // address windows of 8 KiB, selected by address[15:13]
   localparam logic [2:0] WIN_ROM_LO0 = 3'd0;
   localparam logic [2:0] WIN_ROM_LO1 = 3'd1;
   localparam logic [2:0] WIN_ROM_HI0 = 3'd2;
   localparam logic [2:0] WIN_ROM_HI1 = 3'd3;
   localparam logic [2:0] WIN_VIDEO   = 3'd4;
   localparam logic [2:0] WIN_XRAM    = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_BOOT_DONE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROM_SIZE  = 1'b1;

   localparam logic [ADDR_W-1:0]     BOOT_LIMIT     = 16'h0100;
   localparam logic [DATA_W-1:0]     ENABLE_KEY     = 8'h0A;
   localparam logic [DATA_W-1:0]     EXT_BANK_MAX   = 8'h03;
   localparam logic [DATA_W-1:0]     CLK_SEL_LO     = 8'h08;
   localparam logic [DATA_W-1:0]     CLK_SEL_HI     = 8'h0C;
   localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = 7'd1;
   localparam logic [ROM_SIZE_W-1:0] ROM_SIZE_RESET = 22'd32768;

   typedef struct packed {
      logic [ROM_BANK_W-1:0] rom_bank;
      logic [EXT_BANK_W-1:0] ext_bank;
      logic                  ram_mode;
      logic                  ram_enable;
      logic [CLK_SEL_W-1:0]  clock_select;
   } bank_state_type;

   typedef struct packed {
      logic                  boot_done;
      logic [ROM_SIZE_W-1:0] rom_size_bytes;
   } csr_type;

   typedef struct packed {
      target_type            target;
      logic [OFFSET_W-1:0]   mem_offset;
      logic                  ext_ram_on;
   } result_type;

endpackage

// ===== hdl/cbc_req_if.sv =====
// bus access channel into the controller
interface cbc_req_if import cbc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              command;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, output command, output address, output write_data,
                   input ready);
   modport sink   (input valid, input command, input address, input write_data,
                   output ready);
endinterface

// ===== hdl/cbc_rsp_if.sv =====
// translated access channel out of the controller
interface cbc_rsp_if import cbc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [2:0]          target;
   logic [OFFSET_W-1:0] mem_offset;
   logic                ext_ram_on;

   modport source (output valid, output target, output mem_offset, output ext_ram_on,
                   input ready);
   modport sink   (input valid, input target, input mem_offset, input ext_ram_on,
                   output ready);
endinterface

// ===== hdl/cartridge_bank_controller.sv =====
// top level of the cartridge bank controller
//
// Translates CPU bus accesses for an MBC3-style cartridge. Each word on
// req_ch is a read or a write with an address and a data byte; each one
// yields exactly one word on rsp_ch with the target memory (boot ROM,
// cartridge ROM, extra RAM, open bus, fault, or write done), the byte
// offset into that memory and the RAM-enable latch after the access.
// Writes update the bank latches; banked ROM reads in RAM mode are
// checked against the ROM size and fault when they reach it.
// A word accepted into the input register is decoded there, and the decode
// is captured in the result register, where rsp valid rises; a stall on
// rsp_ch can hold the word in the input register in between.
// Throughput is one word per cycle while rsp_ch takes words; bank latches update as a word leaves
// the input register, so the following word already sees them.
// When rsp_ch stalls, both registers hold and req_ch.ready drops once
// they are full; nothing is lost. csr_wr_en writes boot_done (index 0) or
// rom_size_bytes (index 1); write them only while the block is idle.
// Synchronous reset empties both registers, clears the latches (ROM bank
// 1), clears boot_done and sets rom_size_bytes to 32768.
module cartridge_bank_controller import cbc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   cbc_req_if.sink               req_ch,
   cbc_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   `include "cartridge_bank_controller_assert.svh"

   logic                in_valid_ff, in_valid_in;
   logic                in_command_ff;
   logic [ADDR_W-1:0]   in_address_ff;
   logic [DATA_W-1:0]   in_data_ff;
   logic                out_valid_ff, out_valid_in;
   result_type          out_result_ff;
   bank_state_type      state_ff, state_in;
   csr_type             csr_ff, csr_in;
   result_type          result;
   logic                advance;
   logic                accept;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign accept = req_ch.valid && req_ch.ready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   cbc_decode u_decode (
      .command    (in_command_ff),
      .address    (in_address_ff),
      .write_data (in_data_ff),
      .csr        (csr_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result)
   );

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BOOT_DONE: csr_in.boot_done      = csr_wr_data[0];
            CSR_ROM_SIZE:  csr_in.rom_size_bytes = csr_wr_data[ROM_SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                 <= 1'b0;
         out_valid_ff                <= 1'b0;
         state_ff.rom_bank           <= ROM_BANK_RESET;
         state_ff.ext_bank           <= '0;
         state_ff.ram_mode           <= 1'b0;
         state_ff.ram_enable         <= 1'b0;
         state_ff.clock_select       <= '0;
         csr_ff.boot_done            <= 1'b0;
         csr_ff.rom_size_bytes       <= ROM_SIZE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         csr_ff       <= csr_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_command_ff <= req_ch.command;
         in_address_ff <= req_ch.address;
         in_data_ff    <= req_ch.write_data;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.target      = out_result_ff.target;
   assign rsp_ch.mem_offset  = out_result_ff.mem_offset;
   assign rsp_ch.ext_ram_on  = out_result_ff.ext_ram_on;

   `CBC_ASSERT_ALWAYS(a_clock_select_range,
      state_ff.clock_select == '0 ||
      (state_ff.clock_select >= CLK_SEL_LO[CLK_SEL_W-1:0] &&
       state_ff.clock_select <= CLK_SEL_HI[CLK_SEL_W-1:0]))
   `CBC_ASSERT_NEXT(a_stalled_word_kept, in_valid_ff && !advance, in_valid_ff)
   `CBC_ASSERT_ALWAYS(a_no_offset_without_memory,
      !out_valid_ff || out_result_ff.mem_offset == '0 ||
      out_result_ff.target == TGT_BOOT || out_result_ff.target == TGT_ROM ||
      out_result_ff.target == TGT_XRAM)

endmodule

// ===== hdl/cbc_decode.sv =====
// access decode: bank latch updates on writes, target and offset on reads
module cbc_decode import cbc_pkg::*; (
   input  logic                command,
   input  logic [ADDR_W-1:0]   address,
   input  logic [DATA_W-1:0]   write_data,
   input  csr_type             csr,
   input  bank_state_type      state,
   output bank_state_type      state_next,
   output result_type          result
);

   logic [OFFSET_W-1:0] banked_offset;
   logic [OFFSET_W-1:0] xram_offset;

   assign banked_offset = {state.rom_bank, address[ROM_PAGE_W-1:0]};
   assign xram_offset   = state.ram_mode
                        ? {{(OFFSET_W-EXT_BANK_W-RAM_PAGE_W){1'b0}},
                           state.ext_bank, address[RAM_PAGE_W-1:0]}
                        : {{(OFFSET_W-RAM_PAGE_W){1'b0}}, address[RAM_PAGE_W-1:0]};

   always_comb begin
      state_next        = state;
      result.target     = TGT_OPEN;
      result.mem_offset = '0;
      if (command) begin
         result.target = TGT_WDONE;
         unique case (address[ADDR_W-1:ADDR_W-3])
            WIN_ROM_LO0: begin
               state_next.ram_enable = (write_data == ENABLE_KEY);
            end
            WIN_ROM_LO1: begin
               state_next.rom_bank = (write_data == '0) ? ROM_BANK_RESET
                                                        : write_data[ROM_BANK_W-1:0];
            end
            WIN_ROM_HI0: begin
               if (write_data <= EXT_BANK_MAX) begin
                  state_next.ext_bank = write_data[EXT_BANK_W-1:0];
                  state_next.ram_mode = 1'b1;
               end else if (write_data >= CLK_SEL_LO && write_data <= CLK_SEL_HI) begin
                  state_next.clock_select = write_data[CLK_SEL_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end else if (address < BOOT_LIMIT && !csr.boot_done) begin
         result.target     = TGT_BOOT;
         result.mem_offset = {{(OFFSET_W-ADDR_W){1'b0}}, address};
      end else begin
         unique case (address[ADDR_W-1:ADDR_W-3]) inside
            WIN_ROM_LO0, WIN_ROM_LO1: begin
               result.target     = TGT_ROM;
               result.mem_offset = {{(OFFSET_W-ADDR_W){1'b0}}, address};
            end
            WIN_ROM_HI0, WIN_ROM_HI1: begin
               if (!state.ram_mode) begin
                  result.target     = TGT_ROM;
                  result.mem_offset = {{(OFFSET_W-ADDR_W){1'b0}}, address};
               end else if ({1'b0, banked_offset} >= csr.rom_size_bytes) begin
                  result.target = TGT_FAULT;
               end else begin
                  result.target     = TGT_ROM;
                  result.mem_offset = banked_offset;
               end
            end
            WIN_XRAM: begin
               result.target     = TGT_XRAM;
               result.mem_offset = xram_offset;
            end
            default: begin
               result.target = TGT_OPEN;
            end
         endcase
      end
      result.ext_ram_on = state_next.ram_enable;
   end

endmodule

// ===== tb/cartridge_bank_controller_tb.sv =====
// testbench for the cartridge bank controller: directed and random bus accesses, scoreboarded
`timescale 1ns / 100ps

module cartridge_bank_controller_tb import cbc_pkg::*; ();

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;
   localparam int   NUM_PHASES = 6;
   localparam int   PHASE_WORDS = 80;

   class translation_scoreboard;
      csr_type        csr;
      bank_state_type bank;
      result_type     expected_translations[$];
      int unsigned    error_count;

      function new();
         csr.boot_done      = 1'b0;
         csr.rom_size_bytes = ROM_SIZE_RESET;
         bank.rom_bank      = ROM_BANK_RESET;
         bank.ext_bank      = '0;
         bank.ram_mode      = 1'b0;
         bank.ram_enable    = 1'b0;
         bank.clock_select  = '0;
         error_count        = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_BOOT_DONE: csr.boot_done = value[0];
            CSR_ROM_SIZE:  csr.rom_size_bytes = value[ROM_SIZE_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_translations.size();
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         error_count++;
      endtask

      // bank latches change as the word is taken, reads see the latches as they stand
      function void note_access(logic cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
         result_type            res;
         logic [ROM_SIZE_W-1:0] rom_off;
         res.target     = TGT_OPEN;
         res.mem_offset = '0;
         if (cmd == CMD_WRITE) begin
            res.target = TGT_WDONE;
            case (addr[15:13])
               WIN_ROM_LO0: bank.ram_enable = (data == ENABLE_KEY);
               WIN_ROM_LO1: bank.rom_bank = (data == '0) ? 7'd1 : data[ROM_BANK_W-1:0];
               WIN_ROM_HI0: begin
                  if (data <= EXT_BANK_MAX) begin
                     bank.ext_bank = data[EXT_BANK_W-1:0];
                     bank.ram_mode = 1'b1;
                  end else if (data >= CLK_SEL_LO && data <= CLK_SEL_HI) begin
                     bank.clock_select = data[CLK_SEL_W-1:0];
                  end
               end
               default: ;
            endcase
         end else if (addr < BOOT_LIMIT && !csr.boot_done) begin
            res.target     = TGT_BOOT;
            res.mem_offset = OFFSET_W'(addr);
         end else if (addr < 16'h4000) begin
            res.target     = TGT_ROM;
            res.mem_offset = OFFSET_W'(addr);
         end else if (addr < 16'h8000) begin
            res.target = TGT_ROM;
            if (bank.ram_mode) begin
               rom_off = {1'b0, bank.rom_bank, addr[ROM_PAGE_W-1:0]};
               // the offset reaching the rom size already faults
               if (rom_off >= csr.rom_size_bytes)
                  res.target = TGT_FAULT;
               else
                  res.mem_offset = rom_off[OFFSET_W-1:0];
            end else begin
               res.mem_offset = OFFSET_W'(addr);
            end
         end else if (addr >= 16'hA000 && addr < 16'hC000) begin
            res.target = TGT_XRAM;
            if (bank.ram_mode)
               res.mem_offset = OFFSET_W'({bank.ext_bank, addr[RAM_PAGE_W-1:0]});
            else
               res.mem_offset = OFFSET_W'(addr[RAM_PAGE_W-1:0]);
         end
         res.ext_ram_on = bank.ram_enable;
         expected_translations.push_back(res);
      endfunction

      task check_translation(logic [2:0] tgt, logic [OFFSET_W-1:0] off, logic en);
         result_type exp_res;
         if (expected_translations.size() == 0) begin
            report_mismatch($sformatf("word out with nothing expected, target %0d", tgt));
            return;
         end
         exp_res = expected_translations.pop_front();
         if (tgt !== exp_res.target)
            report_mismatch($sformatf("target %0d, expected %0d", tgt, exp_res.target));
         if (off !== exp_res.mem_offset)
            report_mismatch($sformatf("mem_offset 0x%0h, expected 0x%0h",
                                      off, exp_res.mem_offset));
         if (en !== exp_res.ext_ram_on)
            report_mismatch($sformatf("ext_ram_on %0b, expected %0b", en, exp_res.ext_ram_on));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   bit                    burst_mode = 1'b0;
   int unsigned           hold_rsp_cycles = 0;
   translation_scoreboard board;

   cbc_req_if req_if ();
   cbc_rsp_if rsp_if ();

   cartridge_bank_controller u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      req_if.valid      = 1'b0;
      req_if.command    = CMD_READ;
      req_if.address    = '0;
      req_if.write_data = '0;
      board = new();
   end

   function automatic int unsigned idle_cycles();
      return burst_mode ? 0 : $urandom_range(0, 11);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready)
            board.check_translation(rsp_if.target, rsp_if.mem_offset, rsp_if.ext_ram_on);
         if (req_if.valid && req_if.ready)
            board.note_access(req_if.command, req_if.address, req_if.write_data);
      end
   end

   // result side: random stalls, plus a long hold-off when asked
   initial begin : rsp_side
      int unsigned stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp_cycles != 0) begin
            rsp_if.ready = 1'b0;
            repeat (hold_rsp_cycles) @(negedge clock);
            hold_rsp_cycles = 0;
         end
         stall = idle_cycles();
         if (stall != 0) begin
            rsp_if.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready = 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // starts and ends at a falling edge
   task automatic send_access(input logic cmd, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
      int unsigned gap;
      gap = idle_cycles();
      if (gap != 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid      = 1'b1;
      req_if.command    = cmd;
      req_if.address    = addr;
      req_if.write_data = data;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_if.valid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = value;
      board.write_register(idx, value);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic send_random_access();
      int unsigned        pick;
      logic               cmd;
      logic [ADDR_W-1:0]  addr;
      logic [DATA_W-1:0]  data;
      pick = $urandom_range(0, 99);
      cmd  = CMD_READ;
      addr = ADDR_W'($urandom);
      data = DATA_W'($urandom);
      if (pick < 12) begin
         cmd  = CMD_WRITE;
         addr = ADDR_W'($urandom_range(16'h0000, 16'h1FFF));
         if ($urandom_range(0, 1) == 0)
            data = ENABLE_KEY;
      end else if (pick < 24) begin
         cmd  = CMD_WRITE;
         addr = ADDR_W'($urandom_range(16'h2000, 16'h3FFF));
         // small banks keep banked reads inside small roms
         case ($urandom_range(0, 3))
            0: data = '0;
            1: data = DATA_W'($urandom_range(0, 7));
            default: ;
         endcase
      end else if (pick < 34) begin
         cmd  = CMD_WRITE;
         addr = ADDR_W'($urandom_range(16'h4000, 16'h5FFF));
         case ($urandom_range(0, 2))
            0: data = DATA_W'($urandom_range(0, EXT_BANK_MAX));
            1: data = DATA_W'($urandom_range(CLK_SEL_LO, CLK_SEL_HI));
            default: ;
         endcase
      end else if (pick < 38) begin
         cmd = CMD_WRITE;
      end else if (pick < 48) begin
         addr = ADDR_W'($urandom_range(0, 16'h01FF));
      end else if (pick < 70) begin
         addr = ADDR_W'($urandom_range(16'h4000, 16'h7FFF));
      end else if (pick < 80) begin
         addr = ADDR_W'($urandom_range(16'hA000, 16'hBFFF));
      end
      send_access(cmd, addr, data);
   endtask

   // ram mode is still off here, and it is never cleared once set
   task automatic send_directed();
      send_access(CMD_READ, 16'h0000, 8'h00);
      send_access(CMD_READ, 16'h00FF, 8'hFF);
      send_access(CMD_READ, 16'h0100, 8'h00);
      send_access(CMD_READ, 16'h3FFF, 8'h00);
      send_access(CMD_READ, 16'h4000, 8'h00);
      send_access(CMD_READ, 16'h7FFF, 8'h00);
      send_access(CMD_READ, 16'h8000, 8'h00);
      send_access(CMD_READ, 16'h9FFF, 8'h00);
      send_access(CMD_READ, 16'hA000, 8'h00);
      send_access(CMD_READ, 16'hBFFF, 8'h00);
      send_access(CMD_READ, 16'hC000, 8'h00);
      send_access(CMD_READ, 16'hFFFF, 8'h00);
      send_access(CMD_WRITE, 16'h0000, ENABLE_KEY);
      send_access(CMD_WRITE, 16'h1FFF, 8'h0B);
      send_access(CMD_WRITE, 16'h1000, ENABLE_KEY);
      send_access(CMD_WRITE, 16'h5FFF, EXT_BANK_MAX);
      send_access(CMD_READ, 16'hBFFF, 8'h00);
      // bit 7 alone leaves bank zero, only a zero byte maps to bank one
      send_access(CMD_WRITE, 16'h2000, 8'h80);
      send_access(CMD_READ, 16'h4000, 8'h00);
      send_access(CMD_WRITE, 16'h3FFF, 8'h00);
      send_access(CMD_READ, 16'h7FFF, 8'h00);
      // bank 2 starts exactly at the default rom size
      send_access(CMD_WRITE, 16'h2000, 8'h02);
      send_access(CMD_READ, 16'h4000, 8'h00);
      send_access(CMD_WRITE, 16'h4000, CLK_SEL_HI);
      send_access(CMD_WRITE, 16'h4000, 8'h07);
      send_access(CMD_WRITE, 16'h6000, 8'hFF);
      send_access(CMD_WRITE, 16'h2000, 8'hFF);
      send_access(CMD_READ, 16'h7FFF, 8'h00);
   endtask

   initial begin
      logic                  boot_setting [NUM_PHASES];
      logic [CSR_DATA_W-1:0] size_setting [NUM_PHASES];
      int unsigned           wait_count;
      result_type            leftover;

      boot_setting = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
      size_setting[0] = 22'd2097152;
      size_setting[1] = 22'd0;
      size_setting[2] = CSR_DATA_W'(16384 * $urandom_range(1, 127));
      size_setting[3] = CSR_DATA_W'($urandom_range(0, 2097152));
      size_setting[4] = ROM_SIZE_RESET;
      size_setting[5] = CSR_DATA_W'($urandom_range(1, 2097151));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_directed();
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         write_csr(CSR_BOOT_DONE, CSR_DATA_W'(boot_setting[p]));
         write_csr(CSR_ROM_SIZE, size_setting[p]);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 16 == 0)
               burst_mode = ($urandom_range(0, 3) == 0);
            // back up the result side long enough to stall the input
            if (p == 2 && n == 20) begin
               burst_mode      = 1'b1;
               hold_rsp_cycles = 48;
            end
            // sender waits for every word to come back, mid-phase
            if (p == 4 && n == 40)
               drain();
            send_random_access();
         end
      end

      req_if.valid = 1'b0;
      wait_count = 0;
      while (board.pending() != 0 && wait_count < 5000) begin
         @(negedge clock);
         wait_count++;
      end
      repeat (8) @(negedge clock);
      while (board.pending() != 0) begin
         leftover = board.expected_translations.pop_front();
         board.report_mismatch($sformatf("no word out for expected target %0d",
                                         leftover.target));
      end

      if (board.error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cbc_pkg.sv
hdl/cbc_req_if.sv
hdl/cbc_rsp_if.sv
hdl/cbc_decode.sv
hdl/cartridge_bank_controller.sv
tb/cartridge_bank_controller_tb.sv
